/* hdl/ray_sphere_intersect_defines.svh */
// Assertion macros for the ray/sphere intersection block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef RAY_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check gated off while reset is asserted
`define RSI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also holds through reset
`define RSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSI_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hdl/rsi_pkg.sv */
// Shared constants, types and helpers for the ray/sphere intersection block.
// No dependencies.
package rsi_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = CFG_IDX_W'(3);

  // Square root: 31 root bits from a 62 bit radicand, one bit per stage
  localparam int unsigned ROOT_W = 31;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;

  // Divider: 64 bit numerator, 33 bit divisor, 31 quotient bits plus overflow
  localparam int unsigned DEN_W  = 33;
  localparam int unsigned QS     = 31;
  localparam int unsigned NUM_W  = DEN_W + QS;
  localparam int unsigned QUO_W  = QS + 1;

  typedef struct packed {
    logic                miss;
    logic [RAD_W-1:0]    disc;
    logic signed [31:0]  b;
    logic [NUM_W-1:0]    cmag;
    logic                cneg;
    logic [30:0]         min_t;
    logic [30:0]         max_t;
  } front_t;

  typedef struct packed {
    logic                miss;
    logic signed [31:0]  b;
    logic [NUM_W-1:0]    cmag;
    logic                cneg;
    logic [30:0]         min_t;
    logic [30:0]         max_t;
  } sq_side_t;

  typedef struct packed {
    logic                miss;
    logic                qzero;
    logic                qneg;
    logic                cneg;
    logic signed [31:0]  t1;
    logic [30:0]         min_t;
    logic [30:0]         max_t;
  } div_side_t;

  // Clamp to the 32 bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* hdl/rsi_ifs.sv */
// Channel interfaces of the ray/sphere intersection block: ray, result, config.
// Depends on rsi_pkg.
interface rsi_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [17:0] dir_x;
  logic signed [17:0] dir_y;
  logic signed [17:0] dir_z;
  logic [30:0]        min_t;
  logic [30:0]        max_t;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  min_t, max_t, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  min_t, max_t, output ready);
endinterface

interface rsi_res_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] hit_t;
  modport source (output valid, hit, hit_t, input ready);
  modport sink   (input valid, hit, hit_t, output ready);
endinterface

interface rsi_cfg_if;
  import rsi_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/ray_sphere_intersect.sv */
// Channel   Dir  Transfer when        Payload
// ray_i     in   valid & ready        origin_x/y/z, dir_x/y/z, min_t, max_t
// res_o     out  valid & ready        hit, hit_t
// cfg_i     in   valid (ready = 1)    index, data -> center_x/y/z, radius
//
// One ray enters per cycle unless the output stalls a full pipeline; each result passes
// through the 31 square root stages and 32 divider stages plus ten more.
// Reset clears valid bits and loads centre 0 and radius 1.0.
// A stalled output holds the whole pipeline only when its last stage is full;
// bubbles still move up, and nothing is dropped or repeated.
// Depends on rsi_pkg, rsi_ifs, rsi_front, rsi_sqrt, rsi_div and the defines header.
`include "ray_sphere_intersect_defines.svh"
module ray_sphere_intersect #(
  parameter int unsigned FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsi_ray_if.sink   ray_i,
  rsi_res_if.source res_o,
  rsi_cfg_if.sink   cfg_i
);
  import rsi_pkg::*;

  localparam int unsigned SQ_SW  = $bits(sq_side_t);
  localparam int unsigned DIV_SW = $bits(div_side_t);

  logic signed [31:0] center_x_q, center_y_q, center_z_q;
  logic [30:0]        radius_q;

  logic               en;
  logic               out_en;

  logic               fv;
  front_t             front;
  sq_side_t           sq_in;
  logic               sv;
  logic [ROOT_W-1:0]  root;
  logic [SQ_SW-1:0]   sq_side_raw;
  sq_side_t           ss;

  logic signed [33:0] qv_d;
  logic [DEN_W-1:0]   qmag_d;
  div_side_t          dside_d;
  logic               vq_q;
  logic [DEN_W-1:0]   qmag_q;
  logic [NUM_W-1:0]   cmag_q;
  div_side_t          dside_q;

  logic               dv;
  logic [QUO_W-1:0]   quo;
  logic [DIV_SW-1:0]  div_side_raw;
  div_side_t          ds;

  logic signed [33:0] t0w_d;
  logic signed [31:0] t0_d, t1_d;
  logic               vt_q;
  logic               miss_t_q;
  logic signed [31:0] lo_q, hi_q;
  logic [30:0]        mn_t_q, mx_t_q;

  logic signed [32:0] lo_w, hi_w, mn_w, mx_w;
  logic               hit_d;
  logic signed [31:0] t_d;
  logic               out_valid_q;
  logic               hit_q;
  logic signed [31:0] hit_t_q;

  // Configuration registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      radius_q   <= 31'(1) << FRAC_BITS;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_CENTER_X: center_x_q <= cfg_i.data;
        REG_CENTER_Y: center_y_q <= cfg_i.data;
        REG_CENTER_Z: center_z_q <= cfg_i.data;
        REG_RADIUS:   radius_q   <= cfg_i.data[30:0];
        default: ;
      endcase
    end
  end

  // Advance the output register when it is empty or taken; advance the rest
  // also when the last stage before it holds a bubble
  assign out_en      = !out_valid_q || res_o.ready;
  assign en          = out_en || !vt_q;
  assign ray_i.ready = en;

  rsi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (ray_i.valid),
    .origin_x_i (ray_i.origin_x),
    .origin_y_i (ray_i.origin_y),
    .origin_z_i (ray_i.origin_z),
    .dir_x_i    (ray_i.dir_x),
    .dir_y_i    (ray_i.dir_y),
    .dir_z_i    (ray_i.dir_z),
    .min_t_i    (ray_i.min_t),
    .max_t_i    (ray_i.max_t),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .center_z_i (center_z_q),
    .radius_i   (radius_q),
    .valid_o    (fv),
    .front_o    (front)
  );

  always_comb begin
    sq_in.miss  = front.miss;
    sq_in.b     = front.b;
    sq_in.cmag  = front.cmag;
    sq_in.cneg  = front.cneg;
    sq_in.min_t = front.min_t;
    sq_in.max_t = front.max_t;
  end

  rsi_sqrt #(.SW(SQ_SW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .rad_i   (front.disc),
    .side_i  (sq_in),
    .valid_o (sv),
    .root_o  (root),
    .side_o  (sq_side_raw)
  );

  assign ss = sq_side_t'(sq_side_raw);

  // Form q = b + sign(b) * sqrt and its magnitude
  assign qv_d = (ss.b > 0) ? (34'(ss.b) + 34'(signed'({1'b0, root})))
                           : (34'(ss.b) - 34'(signed'({1'b0, root})));
  assign qmag_d = qv_d[33] ? DEN_W'(-qv_d) : qv_d[DEN_W-1:0];

  always_comb begin
    dside_d.miss  = ss.miss;
    dside_d.qzero = qv_d == '0;
    dside_d.qneg  = qv_d[33];
    dside_d.cneg  = ss.cneg;
    dside_d.t1    = sat32(64'(qv_d));
    dside_d.min_t = ss.min_t;
    dside_d.max_t = ss.max_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= 1'b0;
    end else if (en) begin
      vq_q <= sv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qmag_q  <= qmag_d;
      cmag_q  <= ss.cmag;
      dside_q <= dside_d;
    end
  end

  rsi_div #(.SW(DIV_SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vq_q),
    .num_i   (cmag_q),
    .den_i   (qmag_q),
    .side_i  (dside_q),
    .valid_o (dv),
    .quo_o   (quo),
    .side_o  (div_side_raw)
  );

  assign ds = div_side_t'(div_side_raw);

  // Signed roots c/q and q, both zero when q is zero
  assign t0w_d = (ds.cneg ^ ds.qneg) ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign t0_d  = ds.qzero ? '0 : sat32(64'(t0w_d));
  assign t1_d  = ds.qzero ? '0 : ds.t1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= 1'b0;
    end else if (en) begin
      vt_q <= dv;
    end
  end

  // Sort the roots
  always_ff @(posedge clk_i) begin
    if (en) begin
      miss_t_q <= ds.miss;
      lo_q     <= (t0_d < t1_d) ? t0_d : t1_d;
      hi_q     <= (t0_d < t1_d) ? t1_d : t0_d;
      mn_t_q   <= ds.min_t;
      mx_t_q   <= ds.max_t;
    end
  end

  // Pick the nearest root inside the interval
  assign lo_w = 33'(lo_q);
  assign hi_w = 33'(hi_q);
  assign mn_w = signed'({2'b00, mn_t_q});
  assign mx_w = signed'({2'b00, mx_t_q});

  always_comb begin
    hit_d = 1'b1;
    t_d   = lo_q;
    priority if (miss_t_q) begin
      hit_d = 1'b0;
    end else if (lo_w > mx_w || hi_w < mn_w) begin
      hit_d = 1'b0;
    end else if (lo_w < mn_w) begin
      t_d   = hi_q;
      hit_d = !(hi_w > mx_w);
    end else begin
      t_d   = lo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= vt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      hit_q   <= hit_d;
      hit_t_q <= hit_d ? t_d : '0;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.hit   = hit_q;
  assign res_o.hit_t = hit_t_q;

  `RSI_ASSERT(a_miss_zero_t, clk_i, rst_ni, (out_valid_q && !hit_q) |-> (hit_t_q == '0), "miss with nonzero distance")
  `RSI_ASSERT(a_hit_nonneg, clk_i, rst_ni, (out_valid_q && hit_q) |-> !hit_t_q[31], "hit with negative distance")
  `RSI_ASSERT(a_stall_keeps, clk_i, rst_ni, (vt_q && !out_en) |=> vt_q, "stalled last stage lost its item")
  `RSI_ASSERT_ALWAYS(a_ready_free, clk_i, !out_valid_q |-> ray_i.ready, "input blocked with empty output")

endmodule

/* hdl/rsi_front.sv */
// Front end pipeline: offset, projection, closest point, squared lengths.
// Seven register stages; depends on rsi_pkg.
module rsi_front #(
  parameter int unsigned FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [17:0] dir_x_i,
  input  logic signed [17:0] dir_y_i,
  input  logic signed [17:0] dir_z_i,
  input  logic [30:0]        min_t_i,
  input  logic [30:0]        max_t_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [30:0]        radius_i,
  output logic               valid_o,
  output rsi_pkg::front_t    front_o
);
  import rsi_pkg::*;

  logic [6:0]          v_q;
  logic signed [31:0]  org [3];
  logic signed [31:0]  ctr [3];
  logic signed [17:0]  dir [3];
  logic [30:0]         mn_q [6];
  logic [30:0]         mx_q [6];
  logic [RAD_W-1:0]    rr_q;

  logic signed [31:0]  f1_q [3], f2_q [3], f3_q [3], f4_q [3];
  logic signed [17:0]  d1_q [3], d2_q [3], d3_q [3];
  logic signed [49:0]  p2_q [3];
  logic signed [63:0]  sqf [3];
  logic [62:0]         ff2_q [3];
  logic signed [51:0]  dot3_d;
  logic signed [52:0]  negd3_d;
  logic signed [31:0]  b3_q, b4_q, b5_q, b6_q;
  logic [63:0]         ff3_q, ff4_q, ff5_q, ff6_q;
  logic signed [49:0]  m4_q [3];
  logic signed [31:0]  l5_q [3];
  logic signed [63:0]  sql [3];
  logic [62:0]         l6_q [3];
  logic [63:0]         ll_d;
  logic [63:0]         rr64;
  front_t              front_d;
  front_t              front_q;

  assign org = '{origin_x_i, origin_y_i, origin_z_i};
  assign ctr = '{center_x_i, center_y_i, center_z_i};
  assign dir = '{dir_x_i, dir_y_i, dir_z_i};

  // Squared radius follows the register; the user must write it only while idle (not enforced here)
  always_ff @(posedge clk_i) begin
    rr_q <= RAD_W'(radius_i) * RAD_W'(radius_i);
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  // Stage 1: offset from centre
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        f1_q[i] <= sat32(64'(org[i]) - 64'(ctr[i]));
        d1_q[i] <= dir[i];
      end
      mn_q[0] <= min_t_i;
      mx_q[0] <= max_t_i;
    end
  end

  // Stage 2: products for f.d and |f|^2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqf[i] = 64'(f1_q[i]) * 64'(f1_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        p2_q[i]  <= f1_q[i] * d1_q[i];
        ff2_q[i] <= sqf[i][62:0];
        f2_q[i]  <= f1_q[i];
        d2_q[i]  <= d1_q[i];
      end
      mn_q[1] <= mn_q[0];
      mx_q[1] <= mx_q[0];
    end
  end

  // Stage 3: b = -(f.d) scaled back, |f|^2 summed
  assign dot3_d  = 52'(p2_q[0]) + 52'(p2_q[1]) + 52'(p2_q[2]);
  assign negd3_d = -(53'(dot3_d));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b3_q  <= sat32(64'(negd3_d >>> FRAC_BITS));
      ff3_q <= 64'(ff2_q[0]) + 64'(ff2_q[1]) + 64'(ff2_q[2]);
      for (int i = 0; i < 3; i++) begin
        f3_q[i] <= f2_q[i];
        d3_q[i] <= d2_q[i];
      end
      mn_q[2] <= mn_q[1];
      mx_q[2] <= mx_q[1];
    end
  end

  // Stage 4: d * b
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m4_q[i] <= d3_q[i] * b3_q;
        f4_q[i] <= f3_q[i];
      end
      b4_q    <= b3_q;
      ff4_q   <= ff3_q;
      mn_q[3] <= mn_q[2];
      mx_q[3] <= mx_q[2];
    end
  end

  // Stage 5: closest point offset l = f + b*d
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        l5_q[i] <= sat32(64'(f4_q[i]) + 64'(m4_q[i] >>> FRAC_BITS));
      end
      b5_q    <= b4_q;
      ff5_q   <= ff4_q;
      mn_q[4] <= mn_q[3];
      mx_q[4] <= mx_q[3];
    end
  end

  // Stage 6: squares of l
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sql[i] = 64'(l5_q[i]) * 64'(l5_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        l6_q[i] <= sql[i][62:0];
      end
      b6_q    <= b5_q;
      ff6_q   <= ff5_q;
      mn_q[5] <= mn_q[4];
      mx_q[5] <= mx_q[4];
    end
  end

  // Stage 7: discriminant, miss test and c = |f|^2 - r^2
  assign ll_d = 64'(l6_q[0]) + 64'(l6_q[1]) + 64'(l6_q[2]);
  assign rr64 = 64'(rr_q);

  always_comb begin
    front_d.miss  = ll_d > rr64;
    front_d.disc  = RAD_W'(rr64 - ll_d);
    front_d.b     = b6_q;
    front_d.cneg  = ff6_q < rr64;
    front_d.cmag  = front_d.cneg ? (rr64 - ff6_q) : (ff6_q - rr64);
    front_d.min_t = mn_q[5];
    front_d.max_t = mx_q[5];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign valid_o = v_q[6];
  assign front_o = front_q;

endmodule

/* hdl/rsi_sqrt.sv */
// Pipelined integer square root, one root bit per register stage.
// Carries a side payload alongside; depends on rsi_pkg.
module rsi_sqrt #(
  parameter int unsigned SW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [rsi_pkg::RAD_W-1:0]  rad_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [rsi_pkg::ROOT_W-1:0] root_o,
  output logic [SW-1:0]              side_o
);
  import rsi_pkg::*;

  logic                v_q    [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [REM_W-1:0]    rem_q  [ROOT_W];
  logic [RAD_W-1:0]    rad_q  [ROOT_W];
  logic [SW-1:0]       side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic              v_p;
    logic [ROOT_W-1:0] root_p;
    logic [REM_W-1:0]  rem_p;
    logic [RAD_W-1:0]  rad_p;
    logic [SW-1:0]     side_p;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_p    = valid_i;
      assign root_p = '0;
      assign rem_p  = '0;
      assign rad_p  = rad_i;
      assign side_p = side_i;
    end else begin : g_next
      assign v_p    = v_q[k-1];
      assign root_p = root_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign side_p = side_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign cur   = {rem_p, rad_p[RAD_W-1 -: 2]};
    assign trial = {2'b00, root_p, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
        root_q[k] <= {root_p[ROOT_W-2:0], ge};
        rad_q[k]  <= rad_p << 2;
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

/* hdl/rsi_div.sv */
// Pipelined restoring divider, one quotient bit per stage, quotient clamped
// at 2^QS. Carries a side payload alongside; depends on rsi_pkg.
module rsi_div #(
  parameter int unsigned SW = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [rsi_pkg::NUM_W-1:0] num_i,
  input  logic [rsi_pkg::DEN_W-1:0] den_i,
  input  logic [SW-1:0]             side_i,
  output logic                      valid_o,
  output logic [rsi_pkg::QUO_W-1:0] quo_o,
  output logic [SW-1:0]             side_o
);
  import rsi_pkg::*;

  // Entry stage: overflow test and first partial remainder
  logic             v0_q;
  logic             ovf0_q;
  logic [DEN_W-1:0] rem0_q;
  logic [QS-1:0]    low0_q;
  logic [DEN_W-1:0] den0_q;
  logic [SW-1:0]    side0_q;

  logic             v_q    [QS];
  logic             ovf_q  [QS];
  logic [DEN_W-1:0] rem_q  [QS];
  logic [QS-1:0]    low_q  [QS];
  logic [DEN_W-1:0] den_q  [QS];
  logic [QS-1:0]    quo_q  [QS];
  logic [SW-1:0]    side_q [QS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf0_q  <= num_i >= {den_i, QS'(0)};
      rem0_q  <= num_i[NUM_W-1:QS];
      low0_q  <= num_i[QS-1:0];
      den0_q  <= den_i;
      side0_q <= side_i;
    end
  end

  for (genvar k = 0; k < QS; k++) begin : g_step
    logic             v_p;
    logic             ovf_p;
    logic [DEN_W-1:0] rem_p;
    logic [QS-1:0]    low_p;
    logic [DEN_W-1:0] den_p;
    logic [QS-1:0]    quo_p;
    logic [SW-1:0]    side_p;
    logic [DEN_W:0]   cur;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_p    = v0_q;
      assign ovf_p  = ovf0_q;
      assign rem_p  = rem0_q;
      assign low_p  = low0_q;
      assign den_p  = den0_q;
      assign quo_p  = '0;
      assign side_p = side0_q;
    end else begin : g_next
      assign v_p    = v_q[k-1];
      assign ovf_p  = ovf_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign low_p  = low_q[k-1];
      assign den_p  = den_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign side_p = side_q[k-1];
    end

    // Shift in the next numerator bit and subtract where it fits
    assign cur = {rem_p, low_p[QS-1]};
    assign ge  = cur >= {1'b0, den_p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DEN_W'(cur - {1'b0, den_p}) : cur[DEN_W-1:0];
        low_q[k]  <= low_p << 1;
        quo_q[k]  <= {quo_p[QS-2:0], ge};
        den_q[k]  <= den_p;
        ovf_q[k]  <= ovf_p;
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = v_q[QS-1];
  assign quo_o   = ovf_q[QS-1] ? (QUO_W'(1) << QS) : {1'b0, quo_q[QS-1]};
  assign side_o  = side_q[QS-1];

endmodule

/* tb/ray_sphere_intersect_tb.sv */
// Self-checking testbench for ray_sphere_intersect: rays and sphere settings in, hit checks out.
// Depends on rsi_pkg and the channel interfaces in rsi_ifs; the expected hits come from
// a bit-exact fixed-point predictor held here.
module ray_sphere_intersect_tb;
  import rsi_pkg::*;

  localparam int FB = 16;
  localparam int PIPE_DEPTH = 73;

  typedef struct packed {
    logic signed [31:0] ox, oy, oz;
    logic signed [17:0] dx, dy, dz;
    logic [30:0]        min_t, max_t;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_t;
  } hit_t_s;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rsi_ray_if ray ();
  rsi_res_if res ();
  rsi_cfg_if cfg ();

  ray_sphere_intersect dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .ray_i (ray),
    .res_o (res),
    .cfg_i (cfg)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sphere as the predictor sees it
  longint           sph_cx, sph_cy, sph_cz;
  longint unsigned  sph_r;

  ray_t   pending_rays[$];
  hit_t_s expected_hits[$];
  int     n_queued, n_sent;
  int     cycle_cnt;
  bit     hold_rays;
  bit     failed;

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned acc, bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  // Nearest intersection within [min_t, max_t], stable quadratic form
  function automatic hit_t_s predict_hit(ray_t r);
    longint          f[3], d[3], l[3];
    longint          dot, b, q, t0, t1, lo, hi, t, mint, maxt;
    longint unsigned ll, ff, rr, disc, s, cmag, qmag, quo;
    bit              cneg, hit;
    hit_t_s          o;
    f[0] = clip32(longint'(r.ox) - sph_cx);
    f[1] = clip32(longint'(r.oy) - sph_cy);
    f[2] = clip32(longint'(r.oz) - sph_cz);
    d[0] = longint'(r.dx);
    d[1] = longint'(r.dy);
    d[2] = longint'(r.dz);
    mint = longint'(r.min_t);
    maxt = longint'(r.max_t);
    dot = f[0] * d[0] + f[1] * d[1] + f[2] * d[2];
    b = clip32((-dot) >>> FB);
    ll = 0;
    ff = 0;
    for (int i = 0; i < 3; i++) begin
      l[i] = clip32(f[i] + ((d[i] * b) >>> FB));
      ll += longint'(unsigned'(l[i] * l[i]));
      ff += longint'(unsigned'(f[i] * f[i]));
    end
    rr = sph_r * sph_r;
    o = '0;
    if (ll > rr) return o;
    disc = rr - ll;
    s = int_root(disc);
    q = (b > 0) ? b + longint'(s) : b - longint'(s);
    if (ff >= rr) begin
      cmag = ff - rr;
      cneg = 1'b0;
    end else begin
      cmag = rr - ff;
      cneg = 1'b1;
    end
    if (q == 0) begin
      t0 = 0;
      t1 = 0;
    end else begin
      qmag = (q < 0) ? longint'(unsigned'(-q)) : longint'(unsigned'(q));
      quo = cmag / qmag;
      if (quo > (64'd1 << 32)) quo = 64'd1 << 32;
      t0 = (cneg != (q < 0)) ? -longint'(quo) : longint'(quo);
      t0 = clip32(t0);
      t1 = clip32(q);
    end
    lo = (t0 < t1) ? t0 : t1;
    hi = (t0 < t1) ? t1 : t0;
    hit = 1'b1;
    t = lo;
    if (lo > maxt || hi < mint) begin
      hit = 1'b0;
    end else if (lo < mint) begin
      t = hi;
      if (hi > maxt) hit = 1'b0;
    end
    if (hit) begin
      o.hit = 1'b1;
      o.hit_t = t[31:0];
    end
    return o;
  endfunction

  // Idle with a chance of 37 in 100, except in one quiet window
  function automatic bit idle_now();
    if (cycle_cnt > 3000 && cycle_cnt < 4500) return 1'b0;
    return $urandom_range(0, 99) < 37;
  endfunction

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Ray driver: predict on each transfer, then offer the next ray
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      ray.valid <= 1'b0;
    end else begin
      if (ray.valid && ray.ready) begin
        expected_hits.push_back(predict_hit({ray.origin_x, ray.origin_y, ray.origin_z,
                                             ray.dir_x, ray.dir_y, ray.dir_z,
                                             ray.min_t, ray.max_t}));
        n_sent <= n_sent + 1;
      end
      if (!ray.valid || ray.ready) begin
        if (pending_rays.size() > 0 && !hold_rays && !idle_now()) begin
          ray_t r;
          r = pending_rays.pop_front();
          ray.valid    <= 1'b1;
          ray.origin_x <= r.ox;
          ray.origin_y <= r.oy;
          ray.origin_z <= r.oz;
          ray.dir_x    <= r.dx;
          ray.dir_y    <= r.dy;
          ray.dir_z    <= r.dz;
          ray.min_t    <= r.min_t;
          ray.max_t    <= r.max_t;
        end else begin
          ray.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure, compare each transfer with the oldest expectation
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_hits.size() == 0) begin
          $error("unexpected result: hit %0b hit_t %0d", res.hit, res.hit_t);
          failed = 1'b1;
        end else begin
          hit_t_s e;
          e = expected_hits.pop_front();
          if (res.hit !== e.hit) begin
            $error("hit: expected %0b actual %0b", e.hit, res.hit);
            failed = 1'b1;
          end
          if (res.hit_t !== e.hit_t) begin
            $error("hit_t: expected %0d actual %0d", e.hit_t, res.hit_t);
            failed = 1'b1;
          end
        end
      end
      res.ready <= !idle_now();
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_CENTER_X: sph_cx = longint'(signed'(val));
      REG_CENTER_Y: sph_cy = longint'(signed'(val));
      REG_CENTER_Z: sph_cz = longint'(signed'(val));
      REG_RADIUS:   sph_r  = 64'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (n_sent != n_queued || expected_hits.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] rad);
    wait_drained();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, rad);
  endtask

  task automatic queue_ray(ray_t r);
    pending_rays.push_back(r);
    n_queued++;
  endtask

  function automatic longint to_q(real x);
    real y;
    y = x * 65536.0;
    if (y > 2147483647.0) return 64'sd2147483647;
    if (y < -2147483648.0) return -64'sd2147483648;
    return longint'($rtoi(y));
  endfunction

  function automatic real urand_real();
    return $urandom_range(0, 2000000) / 1000000.0 - 1.0;
  endfunction

  // Noise ray: origins and interval over their whole range, directions from -1.0 to 1.0 in Q16
  function automatic ray_t noise_ray();
    ray_t r;
    r.ox = $urandom;
    r.oy = $urandom;
    r.oz = $urandom;
    r.dx = 18'($urandom_range(0, 131072) - 65536);
    r.dy = 18'($urandom_range(0, 131072) - 65536);
    r.dz = 18'($urandom_range(0, 131072) - 65536);
    r.min_t = 31'($urandom);
    r.max_t = 31'($urandom);
    return r;
  endfunction

  // Well-formed ray: unit direction pointed near the sphere, interval around it
  function automatic ray_t aimed_ray();
    ray_t r;
    real  vx, vy, vz, n, span, rad, ox, oy, oz;
    longint a, c;
    do begin
      vx = urand_real();
      vy = urand_real();
      vz = urand_real();
      n = $sqrt(vx * vx + vy * vy + vz * vz);
    end while (n < 0.05);
    vx /= n;
    vy /= n;
    vz /= n;
    rad = sph_r / 65536.0;
    span = (rad + 0.5) * (0.5 + 4.0 * ($urandom_range(0, 1000) / 1000.0));
    if ($urandom_range(0, 9) == 0) span = 0.0;
    ox = sph_cx / 65536.0 - vx * span + 1.3 * rad * urand_real();
    oy = sph_cy / 65536.0 - vy * span + 1.3 * rad * urand_real();
    oz = sph_cz / 65536.0 - vz * span + 1.3 * rad * urand_real();
    r.ox = 32'(to_q(ox));
    r.oy = 32'(to_q(oy));
    r.oz = 32'(to_q(oz));
    r.dx = 18'(to_q(vx));
    r.dy = 18'(to_q(vy));
    r.dz = 18'(to_q(vz));
    a = $urandom_range(0, 3) == 0 ? 0 : to_q(span * (0.5 + urand_real()));
    c = $urandom_range(0, 3) == 0 ? 64'sd2147483647 : to_q(span + 3.0 * rad + urand_real());
    if (a < 0) a = 0;
    if (c < 0) c = 0;
    r.min_t = a[30:0];
    r.max_t = c[30:0];
    if ($urandom_range(0, 19) == 0) r.min_t = 31'($urandom);
    return r;
  endfunction

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 80) queue_ray(aimed_ray());
      else queue_ray(noise_ray());
    end
  endtask

  // Extremes, inverted interval, tangent and degenerate rays
  task automatic queue_directed();
    queue_ray('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 18'sd65536, 18'sd0, 18'sd0,
                31'd0, 31'h7fffffff});
    queue_ray('{32'sh80000000, 32'sh80000000, 32'sh80000000, -18'sd65536, -18'sd65536,
                -18'sd65536, 31'h7fffffff, 31'h7fffffff});
    queue_ray('{-32'sd5 << 16, 32'sd0, 32'sd0, 18'sd65536, 18'sd0, 18'sd0, 31'd0,
                31'h7fffffff});
    queue_ray('{-32'sd5 << 16, 32'sd0, 32'sd0, 18'sd65536, 18'sd0, 18'sd0, 31'd5 << 16,
                31'd1 << 16});
    queue_ray('{-32'sd5 << 16, 32'sd0, 32'sd0, 18'sd65536, 18'sd0, 18'sd0, 31'd5 << 16,
                31'd5 << 16});
    queue_ray('{-32'sd5 << 16, 32'sd0, 32'sd0, 18'sd65536, 18'sd0, 18'sd0, 31'd0, 31'd0});
    queue_ray('{-32'sd5 << 16, 32'sd1 << 16, 32'sd0, 18'sd65536, 18'sd0, 18'sd0, 31'd0,
                31'h7fffffff});
    queue_ray('{-32'sd5 << 16, 32'sd2 << 16, 32'sd0, 18'sd65536, 18'sd0, 18'sd0, 31'd0,
                31'h7fffffff});
    queue_ray('{32'sd0, 32'sd0, 32'sd0, 18'sd0, 18'sd65536, 18'sd0, 31'd0, 31'h7fffffff});
    queue_ray('{32'sd0, 32'sd0, 32'sd0, 18'sd0, 18'sd0, 18'sd0, 31'd0, 31'h7fffffff});
    queue_ray('{32'sd3 << 16, 32'sd0, 32'sd0, 18'sd65536, 18'sd65536, -18'sd65536, 31'd0,
                31'h7fffffff});
    queue_ray('{32'sd0, -32'sd9 << 16, 32'sd0, 18'sd0, 18'sd65536, 18'sd0, 31'd9 << 16,
                31'd20 << 16});
    queue_ray('{32'sd0, 32'sd0, 32'sd7 << 16, 18'sd0, 18'sd0, -18'sd65536, 31'd0,
                31'd4 << 16});
    queue_ray('{32'sd1, 32'sd0, 32'sd0, 18'sd1, 18'sd0, 18'sd0, 31'd0, 31'h7fffffff});
  endtask

  initial begin
    ray.valid = 1'b0;
    ray.origin_x = '0;
    ray.origin_y = '0;
    ray.origin_z = '0;
    ray.dir_x = '0;
    ray.dir_y = '0;
    ray.dir_z = '0;
    ray.min_t = '0;
    ray.max_t = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    sph_cx = 0;
    sph_cy = 0;
    sph_cz = 0;
    sph_r = 64'd1 << FB;
    n_queued = 0;
    n_sent = 0;
    cycle_cnt = 0;
    hold_rays = 1'b0;
    failed = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset sphere, then a few rays through it
    queue_directed();
    queue_random(150);

    // Unit sphere rewritten; hold the sender once until all results are back
    set_sphere(32'd0, 32'd0, 32'd0, 32'd1 << 16);
    queue_random(200);
    while (n_sent != n_queued) @(posedge clk);
    hold_rays = 1'b1;
    while (expected_hits.size() != 0) @(posedge clk);
    hold_rays = 1'b0;
    queue_random(200);

    // Zero radius: q collapses to zero for a ray from the centre
    set_sphere(32'sd3 << 16, -32'sd2 << 16, 32'sd1 << 16, 32'd0);
    queue_ray('{32'sd3 << 16, -32'sd2 << 16, 32'sd1 << 16, 18'sd0, 18'sd0, 18'sd0, 31'd0,
                31'h7fffffff});
    queue_random(150);

    // Largest radius
    set_sphere(32'd0, 32'd0, 32'd0, 32'h7fffffff);
    queue_directed();
    queue_random(200);

    // Centre at the top and bottom of the range
    set_sphere(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'd100 << 16);
    queue_random(200);
    set_sphere(32'h80000000, 32'h80000000, 32'h80000000, 32'd50 << 16);
    queue_random(200);

    // Random moderate sphere
    set_sphere($urandom_range(0, 32'h00ffffff) - 32'h00800000,
               $urandom_range(0, 32'h00ffffff) - 32'h00800000,
               $urandom_range(0, 32'h00ffffff) - 32'h00800000,
               $urandom_range(1 << 14, 32'd40 << 16));
    queue_random(400);

    wait_drained();
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
